@@ rtl/weighted_histogram_bincount_assert.svh @@
// Assertion macros shared by the histogram RTL.
// Each macro samples on the rising edge of clk and is switched off while rst is high.
`ifndef WEIGHTED_HISTOGRAM_BINCOUNT_ASSERT_SVH
`define WEIGHTED_HISTOGRAM_BINCOUNT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WHB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WHB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/whb_pkg.sv @@
package whb_pkg;

  localparam int MAX_BINS_DEF = 256;
  localparam int MAX_ROWS_DEF = 4;

  localparam int DATA_W    = 32;
  localparam int ROW_W     = 2;
  localparam int NBINS_W   = 9;
  localparam int CFG_IDX_W = 2;

  // Item actions.
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BIN_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BINARY_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USE_WEIGHTS = 2'd2;

  localparam logic [NBINS_W-1:0] BIN_LIMIT_RST = 9'd256;

  // Decoded item, handed from the front end to the update stage.
  typedef struct packed {
    logic is_read;
    logic hit;
    logic add_en;
  } whb_ctl_t;

  // Update stage status, seen by the top level.
  typedef struct packed {
    logic busy;
    logic advance;
    logic is_read;
  } whb_stat_t;

endpackage

@@ rtl/weighted_histogram_bincount.sv @@
// Per-row histogram engine: MAX_ROWS tables of MAX_BINS 32-bit bins held in one
// synchronous RAM. An add item bumps, weights or sets one bin and gives no result; a
// read item returns the bin on bin_value, registered after the update stage, and clears it.
// One item is taken per clock when results are taken promptly: the item reads the RAM
// as it is accepted and is written back on the next edge, with the word just written
// forwarded when the next item hits the same bin. While a result is held by out_stall,
// a read waiting behind it keeps in_stall high. After reset a clearing pass zeroes the
// RAM one word a cycle, working through all MAX_ROWS * MAX_BINS words in turn;
// in_stall is high throughout, while configuration writes are taken at any time.
module weighted_histogram_bincount #(
  parameter int MAX_BINS = whb_pkg::MAX_BINS_DEF,
  parameter int MAX_ROWS = whb_pkg::MAX_ROWS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [whb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [whb_pkg::NBINS_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 action,
  input  logic [whb_pkg::ROW_W-1:0]            row,
  input  logic signed [whb_pkg::DATA_W-1:0]    bin_index,
  input  logic signed [whb_pkg::DATA_W-1:0]    weight,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [whb_pkg::DATA_W-1:0]    bin_value
);
  import whb_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int BIN_W = $clog2(MAX_BINS);

  `include "weighted_histogram_bincount_assert.svh"

  logic [NBINS_W-1:0] bin_limit;
  logic               binary_mode;
  logic               use_weights;

  logic               clr_active;
  logic [AW-1:0]      clr_addr;
  logic               clr_last;

  logic               accept;
  logic               row_ok;
  logic               idx_ok;
  whb_ctl_t           in_ctl;
  logic [AW-1:0]      in_addr;

  logic               upd_wr_en;
  logic [AW-1:0]      upd_wr_addr;
  logic [DATA_W-1:0]  upd_wr_data;
  whb_stat_t          stat;
  logic               rd_retire;

  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;
  logic [DATA_W-1:0]  mem_wr_data;
  logic [DATA_W-1:0]  mem_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_limit   <= BIN_LIMIT_RST;
      binary_mode <= 1'b0;
      use_weights <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BIN_LIMIT:   bin_limit   <= cfg_data;
        REG_BINARY_MODE: binary_mode <= cfg_data[0];
        REG_USE_WEIGHTS: use_weights <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign clr_last = (clr_addr == AW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_last) begin
        clr_active <= 1'b0;
      end
    end
  end

  assign in_stall = clr_active || (stat.busy && !stat.advance);
  assign accept   = in_valid && !in_stall;

  // A negative index has its sign bit set and so fails the unsigned compare too.
  assign row_ok = 32'(row) < 32'(MAX_ROWS);
  assign idx_ok = $unsigned(bin_index) < 32'(MAX_BINS);

  assign in_ctl.is_read = (action == ACT_READ);
  assign in_ctl.hit     = row_ok && idx_ok;
  assign in_ctl.add_en  = (action == ACT_ADD) && row_ok && idx_ok &&
                          ($unsigned(bin_index) < 32'(bin_limit));

  assign in_addr = AW'(32'(row) * 32'(MAX_BINS) + 32'(bin_index[BIN_W-1:0]));

  whb_update #(
    .DEPTH(DEPTH)
  ) u_update (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_ctl      (in_ctl),
    .in_addr     (in_addr),
    .in_weight   (weight),
    .rd_data     (mem_rd_data),
    .binary_mode (binary_mode),
    .use_weights (use_weights),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .bin_value   (bin_value),
    .wr_en       (upd_wr_en),
    .wr_addr     (upd_wr_addr),
    .wr_data     (upd_wr_data),
    .stat        (stat)
  );

  assign rd_retire = stat.advance && stat.is_read;

  assign mem_wr_en   = clr_active || upd_wr_en;
  assign mem_wr_addr = clr_active ? clr_addr : upd_wr_addr;
  assign mem_wr_data = clr_active ? '0 : upd_wr_data;

  whb_bin_mem #(
    .DEPTH(DEPTH)
  ) u_bin_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (mem_rd_data)
  );

  `WHB_ASSERT_NOW(a_result_from_read, $rose(out_valid), $past(rd_retire), "stray result")
  `WHB_ASSERT_NOW(a_clear_sweep_full, $fell(clr_active), $past(clr_last), "sweep cut short")
  `WHB_ASSERT_NEXT(a_stage_loaded, accept, stat.busy, "item lost on acceptance")
  `WHB_ASSERT_NOW(a_no_write_clash, clr_active, !upd_wr_en, "update write while clearing")

endmodule

@@ rtl/whb_bin_mem.sv @@
module whb_bin_mem #(
  parameter int DEPTH = whb_pkg::MAX_BINS_DEF * whb_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr,
  input  logic [whb_pkg::DATA_W-1:0]        wr_data,
  input  logic                              rd_en,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr,
  output logic [whb_pkg::DATA_W-1:0]        rd_data
);
  import whb_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // Read-first: a read and a write of the same word at one edge return the old word.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/whb_update.sv @@
module whb_update #(
  parameter int DEPTH = whb_pkg::MAX_BINS_DEF * whb_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  whb_pkg::whb_ctl_t                 in_ctl,
  input  logic [$clog2(DEPTH)-1:0]          in_addr,
  input  logic [whb_pkg::DATA_W-1:0]        in_weight,
  input  logic [whb_pkg::DATA_W-1:0]        rd_data,
  input  logic                              binary_mode,
  input  logic                              use_weights,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic signed [whb_pkg::DATA_W-1:0] bin_value,
  output logic                              wr_en,
  output logic [$clog2(DEPTH)-1:0]          wr_addr,
  output logic [whb_pkg::DATA_W-1:0]        wr_data,
  output whb_pkg::whb_stat_t                stat
);
  import whb_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic              st_valid;
  whb_ctl_t          st_ctl;
  logic [AW-1:0]     st_addr;
  logic [DATA_W-1:0] st_weight;
  logic              fwd_hit;
  logic [DATA_W-1:0] fwd_data;
  logic [DATA_W-1:0] old_value;
  logic [DATA_W-1:0] new_value;
  logic              advance;

  // A read issued at the same edge as a write-back of the same word sees the
  // stale word, so the written value is kept and used in its place.
  assign old_value = fwd_hit ? fwd_data : rd_data;

  always_comb begin
    if (st_ctl.is_read) begin
      new_value = '0;
    end else if (binary_mode) begin
      new_value = DATA_W'(1);
    end else if (use_weights) begin
      new_value = old_value + st_weight;
    end else begin
      new_value = old_value + DATA_W'(1);
    end
  end

  assign advance = st_valid && (!st_ctl.is_read || !out_valid || !out_stall);
  assign wr_en   = advance && (st_ctl.is_read ? st_ctl.hit : st_ctl.add_en);
  assign wr_addr = st_addr;
  assign wr_data = new_value;

  assign stat.busy    = st_valid;
  assign stat.advance = advance;
  assign stat.is_read = st_ctl.is_read;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (accept) begin
      st_valid <= 1'b1;
    end else if (advance) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_ctl    <= in_ctl;
      st_addr   <= in_addr;
      st_weight <= in_weight;
      fwd_hit   <= wr_en && (wr_addr == in_addr);
      fwd_data  <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && st_ctl.is_read) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && st_ctl.is_read) begin
      bin_value <= st_ctl.hit ? old_value : '0;
    end
  end

endmodule

@@ tb/weighted_histogram_bincount_tb.sv @@
`timescale 1ns / 100ps

module weighted_histogram_bincount_tb;
  import whb_pkg::*;

  localparam int HIST_BINS = MAX_BINS_DEF;
  localparam int HIST_ROWS = MAX_ROWS_DEF;
  // Index past the end of the register list; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT = 400000;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [NBINS_W-1:0]        cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic                      action;
  logic [ROW_W-1:0]          row;
  logic signed [DATA_W-1:0]  bin_index;
  logic signed [DATA_W-1:0]  weight;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [DATA_W-1:0]  bin_value;

  // Mirror of the bin store and the registers.
  bit [DATA_W-1:0]  hist_mem [HIST_ROWS*HIST_BINS];
  bit [NBINS_W-1:0] cfg_bins;
  bit               cfg_binary;
  bit               cfg_weighted;
  bit [DATA_W-1:0]  expected_bins [$];

  int items_sent;
  int results_checked;
  int mismatches;
  int quiet_left;
  int cycle_count;

  weighted_histogram_bincount u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .row       (row),
    .bin_index (bin_index),
    .weight    (weight),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .bin_value (bin_value)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, expected_bins.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Applies one accepted item to the mirrored store; a read queues the word it returns.
  function automatic void update_histogram(logic act, logic [ROW_W-1:0] r,
                                           logic [DATA_W-1:0] idx, logic [DATA_W-1:0] w);
    bit in_table;
    int unsigned slot;
    in_table = !idx[DATA_W-1] && (idx < HIST_BINS);
    slot = r * HIST_BINS + (idx % HIST_BINS);
    if (act == ACT_READ) begin
      if (in_table) begin
        expected_bins.push_back(hist_mem[slot]);
        hist_mem[slot] = '0;
      end else begin
        expected_bins.push_back('0);
      end
    end else if (in_table && idx < cfg_bins) begin
      if (cfg_binary)
        hist_mem[slot] = 1;
      else if (cfg_weighted)
        hist_mem[slot] = hist_mem[slot] + w;
      else
        hist_mem[slot] = hist_mem[slot] + 1;
    end
  endfunction

  // Mostly back-to-back, now and then a long pause, sometimes a long run with no gaps.
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if (pick < 3) begin
      quiet_left = $urandom_range(30, 90);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(logic act, logic [ROW_W-1:0] r,
                           logic [DATA_W-1:0] idx, logic [DATA_W-1:0] w);
    int gap;
    @(negedge clk);
    in_valid  <= 1'b1;
    action    <= act;
    row       <= r;
    bin_index <= idx;
    weight    <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    update_histogram(act, r, idx, w);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic add_item(logic [ROW_W-1:0] r, logic [DATA_W-1:0] idx,
                          logic [DATA_W-1:0] w = 32'd1);
    send_item(ACT_ADD, r, idx, w);
  endtask

  task automatic read_item(logic [ROW_W-1:0] r, logic [DATA_W-1:0] idx);
    send_item(ACT_READ, r, idx, $urandom());
  endtask

  // Stops sending and waits until every result is in and the last write has landed.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [NBINS_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_BIN_LIMIT:   cfg_bins = val;
      REG_BINARY_MODE: cfg_binary = val[0];
      REG_USE_WEIGHTS: cfg_weighted = val[0];
      default: ;
    endcase
  endtask

  task automatic set_mode(logic [NBINS_W-1:0] nb, logic bm, logic uw);
    write_reg(REG_BIN_LIMIT, nb);
    write_reg(REG_BINARY_MODE, {{(NBINS_W-1){1'b0}}, bm});
    write_reg(REG_USE_WEIGHTS, {{(NBINS_W-1){1'b0}}, uw});
  endtask

  // Hot bins dominate so that repeated hits and forwarding are exercised.
  function automatic logic [DATA_W-1:0] pick_index();
    int pick;
    int lim;
    int v;
    pick = $urandom_range(0, 9);
    lim = (cfg_bins > HIST_BINS) ? HIST_BINS : int'(cfg_bins);
    if (pick < 6) return $urandom_range(0, 7);
    if (pick < 8) begin
      v = lim - 3 + int'($urandom_range(0, 6));
      return (v < 0) ? 0 : v;
    end
    if (pick == 8) return $urandom_range(0, HIST_BINS - 1);
    return $urandom();
  endfunction

  function automatic logic [DATA_W-1:0] pick_weight();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return int'($urandom_range(0, 15)) - 8;
    if (pick < 8) return $urandom();
    if (pick == 8) return 32'h7FFF_FFFF;
    return 32'h8000_0000;
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_bins.size() == 0) begin
        $error("bin_value: unexpected result %h with nothing outstanding", bin_value);
        mismatches++;
      end else begin
        if (bin_value !== expected_bins[0]) begin
          $error("bin_value mismatch: expected %h, actual %h", expected_bins[0], bin_value);
          mismatches++;
        end
        void'(expected_bins.pop_front());
        results_checked++;
      end
    end
  end

  // Result stall: short bursts mostly, the odd long hold, and stretches with none.
  initial begin
    int pick;
    int len;
    forever begin
      @(negedge clk);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        out_stall <= 1'b0;
        len = $urandom_range(20, 80);
      end else if (pick < 60) begin
        out_stall <= 1'b0;
        len = $urandom_range(1, 4);
      end else if (pick < 95) begin
        out_stall <= 1'b1;
        len = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;
        len = $urandom_range(10, 40);
      end
      repeat (len - 1) @(negedge clk);
    end
  end

  task automatic test_reset_state();
    read_item(2'd0, 32'd0);
    read_item(2'd3, 32'd255);
  endtask

  task automatic test_count_mode();
    add_item(2'd0, 32'd0);
    add_item(2'd0, 32'd0);
    add_item(2'd3, 32'd255);
    read_item(2'd0, 32'd0);
    read_item(2'd3, 32'd255);
  endtask

  // Out-of-range and negative indices must not alias onto real bins.
  task automatic test_range_limits();
    add_item(2'd1, 32'd256);
    add_item(2'd2, 32'hFFFF_FFFF);
    add_item(2'd2, 32'h8000_0000);
    read_item(2'd1, 32'd256);
    read_item(2'd2, 32'h8000_0000);
    read_item(2'd2, 32'd0);
    read_item(2'd2, 32'd255);
  endtask

  task automatic test_weights();
    wait_idle();
    set_mode(9'd256, 1'b0, 1'b1);
    add_item(2'd1, 32'd5, 32'h7FFF_FFFF);
    add_item(2'd1, 32'd5, 32'd1);
    read_item(2'd1, 32'd5);
    add_item(2'd1, 32'd6, 32'hFFFF_FFFF);
    add_item(2'd1, 32'd6, 32'h8000_0000);
    read_item(2'd1, 32'd6);
  endtask

  task automatic test_binary_mode();
    wait_idle();
    set_mode(9'd256, 1'b1, 1'b1);
    add_item(2'd0, 32'd9, 32'd77);
    add_item(2'd0, 32'd9, -32'sd5);
    read_item(2'd0, 32'd9);
  endtask

  // A bin above the bin limit but inside the table still reads back and clears.
  task automatic test_bin_limit();
    wait_idle();
    set_mode(9'd256, 1'b0, 1'b0);
    add_item(2'd0, 32'd20);
    add_item(2'd0, 32'd20);
    wait_idle();
    set_mode(9'd10, 1'b0, 1'b0);
    write_reg(REG_SPARE, 9'h1FF);
    add_item(2'd0, 32'd9);
    add_item(2'd0, 32'd10);
    read_item(2'd0, 32'd9);
    read_item(2'd0, 32'd10);
    read_item(2'd0, 32'd20);
    wait_idle();
    set_mode(9'd0, 1'b0, 1'b0);
    add_item(2'd0, 32'd0);
    read_item(2'd0, 32'd0);
  endtask

  // One data set: random adds with reads mixed in, then bins 0 to 7 of every row are read out.
  task automatic run_random_phase(int n, logic [NBINS_W-1:0] nb, logic bm, logic uw);
    wait_idle();
    set_mode(nb, bm, uw);
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) wait_idle();
      send_item(($urandom_range(0, 99) < 75) ? ACT_ADD : ACT_READ,
                ROW_W'($urandom_range(0, 3)), pick_index(), pick_weight());
    end
    for (int r = 0; r < HIST_ROWS; r++)
      for (int i = 0; i < 8; i++)
        read_item(ROW_W'(r), DATA_W'(i));
  endtask

  task automatic test_random();
    run_random_phase(180, 9'd256, 1'b0, 1'b0);
    run_random_phase(200, 9'd256, 1'b0, 1'b1);
    run_random_phase(100, 9'd256, 1'b1, 1'b0);
    run_random_phase(80, 9'd0, 1'b0, 1'b1);
    run_random_phase(80, 9'd1, 1'b0, 1'b0);
    run_random_phase(180, 9'd511, 1'b0, 1'b1);
    run_random_phase(100, NBINS_W'($urandom_range(1, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    run_random_phase(100, NBINS_W'($urandom_range(1, 255)), 1'b0, 1'b1);
  endtask

  initial begin
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_BIN_LIMIT;
    cfg_data  = '0;
    in_valid  = 1'b0;
    action    = ACT_ADD;
    row       = '0;
    bin_index = '0;
    weight    = '0;
    cfg_bins     = BIN_LIMIT_RST;
    cfg_binary   = 1'b0;
    cfg_weighted = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_count_mode();
    test_range_limits();
    test_weights();
    test_binary_mode();
    test_bin_limit();
    test_random();

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Sent %0d items and checked %0d read results in %0d cycles,", items_sent,
             results_checked, cycle_count);
    $display("across count, weighted and binary modes with bin limits from 0 to 511.");
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/whb_pkg.sv
rtl/whb_bin_mem.sv
rtl/whb_update.sv
rtl/weighted_histogram_bincount.sv
tb/weighted_histogram_bincount_tb.sv
